// ----- src/bfa_pkg.sv -----
package bfa_pkg;

    localparam int MAX_ENTRIES = 8192;
    localparam int WORD_W      = 32;
    localparam int BIT_W       = $clog2(WORD_W);
    localparam int WORDS       = MAX_ENTRIES / WORD_W;
    localparam int WORD_AW     = $clog2(WORDS);
    localparam int NUM_W       = 14;
    localparam int ST_W        = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [NUM_W-1:0] COUNT_CAP   = NUM_W'(MAX_ENTRIES);
    localparam logic [2:0]       REG_ENTRY_COUNT = 3'd0;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } t_scan_res;

endpackage

// ----- src/bfa_ram.sv -----
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/bfa_scan.sv -----
module bfa_scan
    import bfa_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_cmd,
    input  logic              i_last,
    input  logic [BIT_W-1:0]  i_bit,
    output logic [WORD_W-1:0] o_new_word,
    output t_scan_res         o_res
);

    logic [WORD_W-1:0] w_keep;
    logic [WORD_W-1:0] w_busy;
    logic [WORD_W-1:0] w_onehot;

    // bits past the entry count in the last word count as taken
    assign w_keep = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - i_bit);
    assign w_busy = i_last ? (i_word | ~w_keep) : i_word;

    always_comb begin
        o_res.found = 1'b0;
        o_res.pos   = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!w_busy[b]) begin
                o_res.found = 1'b1;
                o_res.pos   = BIT_W'(b);
            end
        end
    end

    always_comb begin
        if (i_cmd == CMD_FREE) begin
            w_onehot = WORD_W'(1) << i_bit;
            o_new_word = i_word & ~w_onehot;
        end else begin
            w_onehot = WORD_W'(1) << o_res.pos;
            o_new_word = i_word | w_onehot;
        end
    end

endmodule

// ----- src/bitmap_first_free_allocator.sv -----
// First-fit entry allocator over a usage bitmap of MAX_ENTRIES bits.
// Input stream: s_axis_tuser selects the command (0 allocate, 1 free),
// s_axis_tdata carries the one-based entry number to free.
// Output stream: one item per command, allocated number and status.
// APB register 0 (byte address 0) holds entry_count; values above the
// capacity act as the capacity.
// An allocate reads one 32-bit bitmap word per cycle through a single scan
// unit and searches up to 256 words, stopping at the first word with a
// free entry or at the last word. A free is a read-modify-write of one word.
// A rejected free or an allocate with a zero count reads no word and goes
// straight to the result.
// One item is in work at a time: s_axis_tready is low from acceptance until
// the result moves into the output register.
// Reset clears every entry at once through per-word valid bits; no clearing
// sweep is needed. A stalled receiver holds the result in the output
// register, and the next item finishes but waits until that one is taken.
module bitmap_first_free_allocator
    import bfa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [13:0] entry_number, [15:14] zero
    input  logic [0:0]  s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [13:0] allocated_number, [15:14] status
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]         r_state, n_state;
    logic               r_cmd, n_cmd;
    logic [WORD_AW-1:0] r_word, n_word;
    logic [WORD_AW-1:0] r_last, n_last;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [NUM_W-1:0]   r_res_num, n_res_num;
    logic [ST_W-1:0]    r_res_st, n_res_st;
    logic [NUM_W-1:0]   r_count;
    logic               r_out_valid, n_out_valid;
    logic [NUM_W-1:0]   r_out_num, n_out_num;
    logic [ST_W-1:0]    r_out_st, n_out_st;
    logic [WORDS-1:0]   r_row_valid;
    logic               r_rd_valid;

    logic [NUM_W-1:0]   w_eff;
    logic [NUM_W-1:0]   w_eff_m1;
    logic [NUM_W-1:0]   w_num;
    logic [NUM_W-1:0]   w_idx;
    logic               w_s_acc;
    logic               w_cfg_we;
    logic               w_we;
    logic [WORD_AW-1:0] w_raddr;
    logic [WORD_W-1:0]  w_rdata;
    logic [WORD_W-1:0]  w_word;
    logic [WORD_W-1:0]  w_new_word;
    t_scan_res          w_res;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite && pready && (paddr == REG_ENTRY_COUNT);
    assign prdata   = (paddr == REG_ENTRY_COUNT) ? {{(32 - NUM_W){1'b0}}, r_count} : '0;

    assign w_eff    = (r_count > COUNT_CAP) ? COUNT_CAP : r_count;
    assign w_eff_m1 = w_eff - NUM_W'(1);
    assign w_num    = s_axis_tdata[NUM_W-1:0];
    assign w_idx    = w_num - NUM_W'(1);

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    // fetch the next word while the current one is evaluated
    assign w_raddr = (r_state == S_EV) ? r_word + WORD_AW'(1) : r_word;
    assign w_word  = r_rd_valid ? w_rdata : '0;
    assign w_we    = (r_state == S_EV) &&
                     ((r_cmd == CMD_FREE) || w_res.found);

    bfa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_word),
        .i_wdata (w_new_word),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bfa_scan u_scan (
        .i_word     (w_word),
        .i_cmd      (r_cmd),
        .i_last     (r_word == r_last),
        .i_bit      (r_bit),
        .o_new_word (w_new_word),
        .o_res      (w_res)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_word      = r_word;
        n_last      = r_last;
        n_bit       = r_bit;
        n_res_num   = r_res_num;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_num   = r_out_num;
        n_out_st    = r_out_st;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    n_cmd     = s_axis_tuser[0];
                    n_res_num = '0;
                    n_res_st  = ST_OK;
                    if (s_axis_tuser[0] == CMD_ALLOC) begin
                        n_word = '0;
                        n_last = w_eff_m1[BIT_W +: WORD_AW];
                        n_bit  = w_eff_m1[BIT_W-1:0];
                        if (w_eff == '0) begin
                            n_res_st = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end else begin
                        n_word = w_idx[BIT_W +: WORD_AW];
                        n_last = w_idx[BIT_W +: WORD_AW];
                        n_bit  = w_idx[BIT_W-1:0];
                        if (w_num == '0 || w_num > w_eff) begin
                            n_res_st = ST_RANGE;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_EV;
            end
            S_EV: begin
                if (r_cmd == CMD_FREE) begin
                    n_state = S_DONE;
                end else if (w_res.found) begin
                    n_res_num = NUM_W'({r_word, w_res.pos}) + NUM_W'(1);
                    n_state   = S_DONE;
                end else if (r_word == r_last) begin
                    n_res_st = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_word = r_word + WORD_AW'(1);
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_num   = r_res_num;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= COUNT_CAP;
            r_row_valid <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (w_cfg_we) begin
                r_count <= pwdata[NUM_W-1:0];
            end
            if (w_we) begin
                r_row_valid[r_word] <= 1'b1;
            end
            r_rd_valid <= r_row_valid[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_word    <= n_word;
        r_last    <= n_last;
        r_bit     <= n_bit;
        r_res_num <= n_res_num;
        r_res_st  <= n_res_st;
        r_out_num <= n_out_num;
        r_out_st  <= n_out_st;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_st, r_out_num};

endmodule

// ----- bench/bitmap_first_free_allocator_tb.sv -----
module bitmap_first_free_allocator_tb
    import bfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 106;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int NUM_TOP      = (1 << NUM_W) - 1;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [ST_W-1:0]  status;
    } t_alloc_result;

    typedef struct packed {
        logic             set_count;
        logic             cmd;
        logic [NUM_W-1:0] value;
        logic             typed;
        logic [NUM_W-1:0] exp_num;
        logic [ST_W-1:0]  exp_st;
    } t_step;

    // count rows rewrite entry_count; item rows carry a typed result where typed is set
    localparam t_step DIRECTED [28] = '{
        '{1'b0, CMD_FREE,  14'd0,     1'b1, 14'd0, ST_RANGE},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd1, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd16383, 1'b1, 14'd2, ST_OK},
        '{1'b0, CMD_FREE,  14'd1,     1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd1, ST_OK},
        '{1'b0, CMD_FREE,  14'd5,     1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_FREE,  14'd8192,  1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_FREE,  14'd8193,  1'b1, 14'd0, ST_RANGE},
        '{1'b0, CMD_FREE,  14'd16383, 1'b1, 14'd0, ST_RANGE},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd3, ST_OK},
        '{1'b1, CMD_ALLOC, 14'd2,     1'b0, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{1'b0, CMD_FREE,  14'd3,     1'b1, 14'd0, ST_RANGE},
        '{1'b0, CMD_FREE,  14'd2,     1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd2, ST_OK},
        '{1'b1, CMD_ALLOC, 14'd0,     1'b0, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{1'b0, CMD_FREE,  14'd1,     1'b1, 14'd0, ST_RANGE},
        '{1'b0, CMD_FREE,  14'd0,     1'b1, 14'd0, ST_RANGE},
        '{1'b1, CMD_ALLOC, 14'd16383, 1'b0, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd4, ST_OK},
        '{1'b0, CMD_FREE,  14'd3,     1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd3, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b0, 14'd0, ST_OK},
        '{1'b1, CMD_ALLOC, 14'd1,     1'b0, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd0, ST_FULL},
        '{1'b0, CMD_FREE,  14'd1,     1'b1, 14'd0, ST_OK},
        '{1'b0, CMD_ALLOC, 14'd0,     1'b1, 14'd1, ST_OK}
    };

    localparam logic [NUM_W-1:0] PHASE_COUNT [PHASES] = '{
        14'd1, 14'd5, 14'd37, 14'd8192, 14'd64, 14'd0,
        14'd100, 14'd16383, 14'd33, 14'd250, 14'd31, 14'd13
    };

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [13:0] entry_number, [15:14] zero
    logic [0:0]  s_axis_tuser  = '0;    // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [13:0] allocated_number, [15:14] status
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    bitmap_first_free_allocator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // allocator mirror
    bit               used_map [MAX_ENTRIES];
    logic [NUM_W-1:0] entry_count_reg = COUNT_CAP;
    t_alloc_result    awaited_results [$];
    t_alloc_result    head_result;

    int mismatches;
    int n_items, n_alloc, n_free, n_full, n_range, n_settings;
    int idle_cycles;
    int rx_stall, rx_calm, hold_left, tx_calm, roll;
    bit hold_req = 1'b0;
    bit hold_done;

    function automatic int usable_entries();
        return (entry_count_reg > COUNT_CAP) ? MAX_ENTRIES : int'(entry_count_reg);
    endfunction

    function automatic t_alloc_result next_alloc_result(logic cmd, logic [NUM_W-1:0] num);
        t_alloc_result res;
        int            lim;
        bit            found;
        lim        = usable_entries();
        res.num    = '0;
        res.status = ST_OK;
        found      = 1'b0;
        if (cmd == CMD_ALLOC) begin
            res.status = ST_FULL;
            for (int i = 0; i < lim && !found; i++) begin
                if (!used_map[i]) begin
                    used_map[i] = 1'b1;
                    res.num     = NUM_W'(i + 1);
                    res.status  = ST_OK;
                    found       = 1'b1;
                end
            end
        end else if (num == 0 || num > lim) begin
            res.status = ST_RANGE;
        end else begin
            used_map[num - 1] = 1'b0;
        end
        return res;
    endfunction

    // mostly numbers in use, then any number in range, zero, just above the count, noise
    function automatic logic [NUM_W-1:0] pick_free_number();
        int lim, sel, probe, tries;
        lim   = usable_entries();
        sel   = $urandom_range(0, 99);
        probe = 0;
        tries = 0;
        if (lim > 0 && sel < 55) begin
            probe = $urandom_range(1, lim);
            while (tries < 8 && !used_map[probe - 1]) begin
                probe = $urandom_range(1, lim);
                tries++;
            end
        end else if (lim > 0 && sel < 75) begin
            probe = $urandom_range(1, lim);
        end else if (sel < 82) begin
            probe = 0;
        end else if (sel < 90) begin
            probe = lim + $urandom_range(1, 3);
        end else begin
            probe = $urandom_range(0, NUM_TOP);
        end
        return NUM_W'(probe);
    endfunction

    function automatic int sender_gap();
        int sel;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        sel = $urandom_range(0, 99);
        if (sel < 3) begin
            tx_calm = $urandom_range(20, 120);
            return 0;
        end
        if (sel < 60) return 0;
        if (sel < 94) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // call right after a rising edge; returns at the edge that accepts the item
    task automatic send_item(logic cmd, logic [NUM_W-1:0] num, logic typed,
                             logic [NUM_W-1:0] tnum, logic [ST_W-1:0] tst);
        int            gap;
        t_alloc_result res;
        gap = sender_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, num};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        res = next_alloc_result(cmd, num);
        if (typed) begin
            res.num    = tnum;
            res.status = tst;
        end
        awaited_results.push_back(res);
        n_items++;
        if (cmd == CMD_ALLOC) n_alloc++;
        else n_free++;
        if (res.status == ST_FULL) n_full++;
        if (res.status == ST_RANGE) n_range++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (awaited_results.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write entry_count, then read it back
    task automatic write_count(logic [NUM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_ENTRY_COUNT;
        pwdata  <= {18'b0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        entry_count_reg = value;
        n_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {18'b0, value}) begin
            $error("entry_count: expected %0d, got %0d", value, prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (rx_stall == 0 && rx_calm == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) rx_calm = $urandom_range(30, 200);
                else if (roll < 7) rx_stall = $urandom_range(15, 60);
                else if (roll < 30) rx_stall = $urandom_range(1, 3);
            end
            if (rx_calm > 0) rx_calm--;
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_results.size() == 0) begin
                $error("unexpected result item: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                head_result = awaited_results.pop_front();
                if (m_axis_tdata[13:0] !== head_result.num) begin
                    $error("allocated_number: expected %0d, got %0d",
                           head_result.num, m_axis_tdata[13:0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:14] !== head_result.status) begin
                    $error("status: expected %0d, got %0d",
                           head_result.status, m_axis_tdata[15:14]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", idle_cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].set_count) begin
                wait_idle();
                write_count(DIRECTED[k].value);
            end else begin
                send_item(DIRECTED[k].cmd, DIRECTED[k].value, DIRECTED[k].typed,
                          DIRECTED[k].exp_num, DIRECTED[k].exp_st);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_count(PHASE_COUNT[ph]);
            // hold the receiver off so the block backs up into its input
            if (ph == 2) hold_req <= 1'b1;
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 60)
                    send_item(CMD_ALLOC, NUM_W'($urandom_range(0, NUM_TOP)), 1'b0, '0, ST_OK);
                else
                    send_item(CMD_FREE, pick_free_number(), 1'b0, '0, ST_OK);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d items (%0d allocate, %0d free) over %0d entry_count settings",
                 n_items, n_alloc, n_free, n_settings);
        $display("Saw %0d full answers and %0d out-of-range answers", n_full, n_range);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
